// File: sv/pfba_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the microprogram ROM for the page frame bitmap allocator.
// Used by pfba_useq, pfba_dpath and page_frame_bitmap_allocator_top; depends on nothing.
package pfba_pkg;

	localparam int MAX_PAGES_DEF = 1024;
	localparam int WORD_BITS = 32;
	localparam int BIT_W = $clog2(WORD_BITS);
	localparam int CFG_W = 11;
	localparam int PAGE_W = 10;
	localparam int CFG_IDX_W = 1;
	localparam int STEP_W = 4;

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE = 2'd1;
	localparam logic [1:0] KIND_INIT = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_AGAIN = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'd1;

	// Microprogram entry points.
	localparam logic [STEP_W-1:0] S_CLR = 4'd0;
	localparam logic [STEP_W-1:0] S_IDLE = 4'd1;
	localparam logic [STEP_W-1:0] S_DK_ALLOC = 4'd2;
	localparam logic [STEP_W-1:0] S_DK_FREE = 4'd3;
	localparam logic [STEP_W-1:0] S_DK_INIT = 4'd4;
	localparam logic [STEP_W-1:0] S_UNUSED = 4'd5;
	localparam logic [STEP_W-1:0] S_AL_PTR = 4'd6;
	localparam logic [STEP_W-1:0] S_AL_RD = 4'd7;
	localparam logic [STEP_W-1:0] S_AL_TEST = 4'd8;
	localparam logic [STEP_W-1:0] S_AL_NONE = 4'd9;
	localparam logic [STEP_W-1:0] S_FR_RD = 4'd10;
	localparam logic [STEP_W-1:0] S_FR_SET = 4'd11;
	localparam logic [STEP_W-1:0] S_FR_RANGE = 4'd12;
	localparam logic [STEP_W-1:0] S_IN_START = 4'd13;
	localparam logic [STEP_W-1:0] S_IN_WR = 4'd14;
	localparam logic [STEP_W-1:0] S_EMIT = 4'd15;

	typedef enum logic [3:0] {
		A_NOP,
		A_CLR,
		A_TAKE,
		A_PTR,
		A_RD,
		A_ATEST,
		A_NONE,
		A_FRD,
		A_FSET,
		A_RANGE,
		A_ISTART,
		A_IWR,
		A_EMIT
	} action_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_ITEM,
		C_K_ALLOC,
		C_K_FREE,
		C_K_INIT,
		C_CNT_ZERO,
		C_WORD_NZ,
		C_BAD_PAGE,
		C_LAST,
		C_OUT_FREE
	} cond_t;

	// When cond holds the step jumps to target; otherwise it stays (hold) or moves on.
	typedef struct packed {
		action_t act;
		cond_t cond;
		logic hold;
		logic [STEP_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic item;
		logic k_alloc;
		logic k_free;
		logic k_init;
		logic cnt_zero;
		logic word_nz;
		logic bad_page;
		logic addr_last;
		logic out_free;
	} flags_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [PAGE_W-1:0] page_number;
	} req_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page_number_out;
		logic [1:0] status;
		logic [CFG_W-1:0] free_count;
	} rsp_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t u;
		case (step)
			S_CLR: u = '{A_CLR, C_LAST, 1'b1, S_IDLE};
			S_IDLE: u = '{A_TAKE, C_ITEM, 1'b1, S_DK_ALLOC};
			S_DK_ALLOC: u = '{A_NOP, C_K_ALLOC, 1'b0, S_AL_PTR};
			S_DK_FREE: u = '{A_NOP, C_K_FREE, 1'b0, S_FR_RD};
			S_DK_INIT: u = '{A_NOP, C_K_INIT, 1'b0, S_IN_START};
			S_UNUSED: u = '{A_NOP, C_ALWAYS, 1'b0, S_EMIT};
			S_AL_PTR: u = '{A_PTR, C_CNT_ZERO, 1'b0, S_AL_NONE};
			S_AL_RD: u = '{A_RD, C_NEVER, 1'b0, S_AL_TEST};
			S_AL_TEST: u = '{A_ATEST, C_WORD_NZ, 1'b1, S_EMIT};
			S_AL_NONE: u = '{A_NONE, C_ALWAYS, 1'b0, S_EMIT};
			S_FR_RD: u = '{A_FRD, C_BAD_PAGE, 1'b0, S_FR_RANGE};
			S_FR_SET: u = '{A_FSET, C_ALWAYS, 1'b0, S_EMIT};
			S_FR_RANGE: u = '{A_RANGE, C_ALWAYS, 1'b0, S_EMIT};
			S_IN_START: u = '{A_ISTART, C_NEVER, 1'b0, S_IN_WR};
			S_IN_WR: u = '{A_IWR, C_LAST, 1'b1, S_EMIT};
			S_EMIT: u = '{A_EMIT, C_OUT_FREE, 1'b1, S_IDLE};
			default: u = '{A_NOP, C_ALWAYS, 1'b0, S_IDLE};
		endcase
		return u;
	endfunction

endpackage

// File: sv/page_frame_bitmap_allocator_top.sv
`timescale 1ns / 1ps
// Page frame bitmap allocator: request, response and configuration channels.
// Instantiates pfba_useq and pfba_dpath; depends on pfba_pkg.
//
// Usage: a request (req_valid, req_stall, req) carries a kind and a page number.
// Allocate takes the lowest free page of the first nonzero bitmap word found
// next-fit from the scan pointer; free returns a page; initialize rebuilds the
// map from first_free_page and total_pages, written over the cfg channel
// (index 0 and 1) while no request is in flight. Every request yields exactly
// one response (rsp_valid, rsp_stall, rsp) with page, status and free count.
// One request is worked on at a time by a microcoded sequencer driving a
// single-port bitmap memory. After dispatch, free reads the page's word and
// sets its bit; allocate reads bitmap words from the scan pointer until one
// is nonzero, or skips the scan when the free count is zero; initialize
// rewrites every bitmap word. After the response load the sequencer returns
// to idle and can take the next request. The response sits in an output
// register, so a new request is taken while it waits; if the receiver stalls,
// the next response waits in its final step until the register empties.
// After reset a clearing pass zeroes the bitmap; requests are stalled meanwhile.
module page_frame_bitmap_allocator_top #(
	parameter int MAX_PAGES = pfba_pkg::MAX_PAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input pfba_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output pfba_pkg::rsp_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [pfba_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pfba_pkg::CFG_W-1:0] cfg_data
);

	pfba_pkg::action_t act;
	pfba_pkg::flags_t flags;

	assign cfg_ready = 1'b1;

	pfba_useq u_useq (
		.clk(clk),
		.arst_n(arst_n),
		.flags(flags),
		.act(act)
	);

	pfba_dpath #(
		.MAX_PAGES(MAX_PAGES)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.act(act),
		.flags(flags),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

endmodule

// File: sv/pfba_useq.sv
`timescale 1ns / 1ps
// Microprogram sequencer: step counter, control ROM lookup and jump condition test.
// Depends on pfba_pkg for the ROM, the action and condition codes and the flag struct.
module pfba_useq (
	input logic clk,
	input logic arst_n,
	input pfba_pkg::flags_t flags,
	output pfba_pkg::action_t act
);

	logic [pfba_pkg::STEP_W-1:0] step_q;
	logic [pfba_pkg::STEP_W-1:0] step_next;
	pfba_pkg::ucode_t uword;
	logic cond_true;

	assign uword = pfba_pkg::ucode_rom(step_q);
	assign act = uword.act;

	always_comb begin
		case (uword.cond)
			pfba_pkg::C_NEVER: cond_true = 1'b0;
			pfba_pkg::C_ALWAYS: cond_true = 1'b1;
			pfba_pkg::C_ITEM: cond_true = flags.item;
			pfba_pkg::C_K_ALLOC: cond_true = flags.k_alloc;
			pfba_pkg::C_K_FREE: cond_true = flags.k_free;
			pfba_pkg::C_K_INIT: cond_true = flags.k_init;
			pfba_pkg::C_CNT_ZERO: cond_true = flags.cnt_zero;
			pfba_pkg::C_WORD_NZ: cond_true = flags.word_nz;
			pfba_pkg::C_BAD_PAGE: cond_true = flags.bad_page;
			pfba_pkg::C_LAST: cond_true = flags.addr_last;
			pfba_pkg::C_OUT_FREE: cond_true = flags.out_free;
			default: cond_true = 1'b0;
		endcase
	end

	always_comb begin
		if (cond_true) begin
			step_next = uword.target;
		end else if (uword.hold) begin
			step_next = step_q;
		end else begin
			step_next = step_q + 1'b1;
		end
	end

	// Reset enters the clearing pass over the bitmap memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= pfba_pkg::S_CLR;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

// File: sv/pfba_dpath.sv
`timescale 1ns / 1ps
// Datapath: bitmap memory, scan pointer, free count, configuration and result registers.
// Driven by the action code from pfba_useq; depends on pfba_pkg.
module pfba_dpath #(
	parameter int MAX_PAGES = pfba_pkg::MAX_PAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input pfba_pkg::action_t act,
	output pfba_pkg::flags_t flags,
	input logic req_valid,
	output logic req_stall,
	input pfba_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output pfba_pkg::rsp_t rsp,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [pfba_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pfba_pkg::CFG_W-1:0] cfg_data
);

	localparam int NUM_WORDS = (MAX_PAGES + pfba_pkg::WORD_BITS - 1) / pfba_pkg::WORD_BITS;
	localparam int WIDX = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int PW = WIDX + pfba_pkg::BIT_W;
	localparam int CW = (PW > pfba_pkg::CFG_W) ? PW : pfba_pkg::CFG_W;
	localparam int CNT_W = $clog2(MAX_PAGES + 1);
	localparam logic [WIDX-1:0] LAST_WORD = WIDX'(NUM_WORDS - 1);

	logic [pfba_pkg::WORD_BITS-1:0] mem [NUM_WORDS];

	logic [WIDX-1:0] addr_q;
	logic [WIDX-1:0] taddr_q;
	logic [WIDX-1:0] ptr_q;
	logic [pfba_pkg::WORD_BITS-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic [pfba_pkg::CFG_W-1:0] first_q;
	logic [pfba_pkg::CFG_W-1:0] total_q;
	logic [1:0] kind_q;
	logic [pfba_pkg::PAGE_W-1:0] page_q;
	logic [pfba_pkg::PAGE_W-1:0] res_page_q;
	logic [1:0] res_status_q;
	logic rsp_valid_q;
	pfba_pkg::rsp_t rsp_q;

	logic accept;
	logic out_free;
	logic word_nz;
	logic already_free;
	logic [WIDX-1:0] addr_next;
	logic [WIDX-1:0] pword;
	logic [pfba_pkg::WORD_BITS-1:0] bit_mask;
	logic [pfba_pkg::CFG_W-1:0] limit;
	logic [CNT_W-1:0] init_cnt;
	logic [pfba_pkg::WORD_BITS-1:0] init_mask;
	logic [pfba_pkg::BIT_W-1:0] low_bit;
	logic [PW-1:0] take_page;
	logic mem_we;
	logic [WIDX-1:0] mem_waddr;
	logic [pfba_pkg::WORD_BITS-1:0] mem_wdata;
	logic mem_re;
	logic [WIDX-1:0] mem_raddr;

	assign req_stall = (act != pfba_pkg::A_TAKE);
	assign accept = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign word_nz = |rd_q;
	assign addr_next = (addr_q == LAST_WORD) ? '0 : addr_q + 1'b1;
	assign pword = WIDX'(page_q[pfba_pkg::PAGE_W-1:pfba_pkg::BIT_W]);
	assign bit_mask = pfba_pkg::WORD_BITS'(1) << page_q[pfba_pkg::BIT_W-1:0];
	assign already_free = |(rd_q & bit_mask);

	// Totals above the capacity of the map are clamped.
	always_comb begin
		if (32'(total_q) > MAX_PAGES) begin
			limit = pfba_pkg::CFG_W'(MAX_PAGES);
		end else begin
			limit = total_q;
		end
	end

	assign init_cnt = (limit > first_q) ? CNT_W'(limit - first_q) : '0;

	// Free bits of the word being rebuilt: pages in [first, limit).
	always_comb begin
		logic [PW-1:0] pg;
		for (int b = 0; b < pfba_pkg::WORD_BITS; b++) begin
			pg = {addr_q, pfba_pkg::BIT_W'(b)};
			init_mask[b] = (CW'(pg) >= CW'(first_q)) && (CW'(pg) < CW'(limit));
		end
	end

	always_comb begin
		low_bit = '0;
		for (int b = pfba_pkg::WORD_BITS - 1; b >= 0; b--) begin
			if (rd_q[b]) begin
				low_bit = pfba_pkg::BIT_W'(b);
			end
		end
	end

	assign take_page = {taddr_q, low_bit};

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = addr_q;
		case (act)
			pfba_pkg::A_CLR: begin
				mem_we = 1'b1;
			end
			pfba_pkg::A_IWR: begin
				mem_we = 1'b1;
				mem_wdata = init_mask;
			end
			pfba_pkg::A_RD: begin
				mem_re = 1'b1;
			end
			pfba_pkg::A_ATEST: begin
				// A hit clears the lowest set bit; a miss fetches the next word.
				if (word_nz) begin
					mem_we = 1'b1;
					mem_waddr = taddr_q;
					mem_wdata = rd_q & (rd_q - 1'b1);
				end else begin
					mem_re = 1'b1;
				end
			end
			pfba_pkg::A_FRD: begin
				mem_re = 1'b1;
				mem_raddr = pword;
			end
			pfba_pkg::A_FSET: begin
				mem_we = !already_free;
				mem_waddr = taddr_q;
				mem_wdata = rd_q | bit_mask;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			taddr_q <= mem_raddr;
		end
		if (accept) begin
			kind_q <= req.kind;
			page_q <= req.page_number;
		end
		case (act)
			pfba_pkg::A_TAKE: begin
				res_page_q <= '0;
				res_status_q <= pfba_pkg::ST_OK;
			end
			pfba_pkg::A_ATEST: begin
				if (word_nz) begin
					res_page_q <= pfba_pkg::PAGE_W'(take_page);
				end
			end
			pfba_pkg::A_NONE: res_status_q <= pfba_pkg::ST_NONE;
			pfba_pkg::A_RANGE: res_status_q <= pfba_pkg::ST_RANGE;
			pfba_pkg::A_FSET: begin
				if (already_free) begin
					res_status_q <= pfba_pkg::ST_AGAIN;
				end
			end
			default: begin
			end
		endcase
		if (act == pfba_pkg::A_EMIT && out_free) begin
			rsp_q <= '{res_page_q, res_status_q, pfba_pkg::CFG_W'(count_q)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			ptr_q <= '0;
			count_q <= '0;
			first_q <= '0;
			total_q <= pfba_pkg::CFG_W'(1024);
			rsp_valid_q <= 1'b0;
		end else begin
			case (act)
				pfba_pkg::A_CLR, pfba_pkg::A_IWR, pfba_pkg::A_RD: addr_q <= addr_next;
				pfba_pkg::A_PTR: addr_q <= ptr_q;
				pfba_pkg::A_ISTART: begin
					addr_q <= '0;
					count_q <= init_cnt;
				end
				pfba_pkg::A_ATEST: begin
					if (word_nz) begin
						ptr_q <= taddr_q;
						count_q <= count_q - 1'b1;
					end else begin
						addr_q <= addr_next;
					end
				end
				pfba_pkg::A_FSET: begin
					if (!already_free) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pfba_pkg::CFG_FIRST_FREE: first_q <= cfg_data;
					pfba_pkg::CFG_TOTAL: total_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (act == pfba_pkg::A_EMIT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign flags = '{
		item: accept,
		k_alloc: (kind_q == pfba_pkg::KIND_ALLOC),
		k_free: (kind_q == pfba_pkg::KIND_FREE),
		k_init: (kind_q == pfba_pkg::KIND_INIT),
		cnt_zero: (count_q == '0),
		word_nz: word_nz,
		bad_page: ({1'b0, page_q} >= limit),
		addr_last: (addr_q == LAST_WORD),
		out_free: out_free
	};

endmodule

// File: test/tb_page_frame_bitmap_allocator_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for page_frame_bitmap_allocator_top: directed and random requests,
// register writes between phases, random idling on both sides. Depends on pfba_pkg and the RTL.
module tb_page_frame_bitmap_allocator_top;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int WORD_BITS = pfba_pkg::WORD_BITS;
	localparam int NUM_WORDS = (pfba_pkg::MAX_PAGES_DEF + WORD_BITS - 1) / WORD_BITS;
	localparam int SETTLE_CYCLES = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 84;

	// Mirrors the allocator state and holds the responses still owed by the block.
	class alloc_scoreboard;
		logic [WORD_BITS-1:0] bitmap [NUM_WORDS];
		int scan_ptr;
		int free_pages;
		int first_free;
		int total;
		pfba_pkg::rsp_t awaited_rsp[$];
		int mismatches;

		function new();
			foreach (bitmap[i])
				bitmap[i] = '0;
			scan_ptr = 0;
			free_pages = 0;
			first_free = 0;
			total = pfba_pkg::MAX_PAGES_DEF;
			mismatches = 0;
		endfunction

		function int page_limit();
			return (total > pfba_pkg::MAX_PAGES_DEF) ? pfba_pkg::MAX_PAGES_DEF : total;
		endfunction

		function void set_reg(input logic [pfba_pkg::CFG_IDX_W-1:0] idx,
				input logic [pfba_pkg::CFG_W-1:0] val);
			if (idx == pfba_pkg::CFG_FIRST_FREE)
				first_free = val;
			else
				total = val;
		endfunction

		function void note_request(input pfba_pkg::req_t r);
			pfba_pkg::rsp_t e;
			int lim;
			int w;
			int b;
			int k;
			bit found;
			e = '0;
			lim = page_limit();
			case (r.kind)
				pfba_pkg::KIND_ALLOC: begin
					found = 1'b0;
					if (free_pages != 0) begin
						w = scan_ptr;
						for (k = 0; k < NUM_WORDS && !found; k++) begin
							if (bitmap[w] != '0)
								found = 1'b1;
							else
								w = (w + 1) % NUM_WORDS;
						end
					end
					if (!found) begin
						e.status = pfba_pkg::ST_NONE;
					end else begin
						scan_ptr = w;
						// Bit 31 is taken when the lower bits are all clear.
						b = 0;
						while (b < WORD_BITS - 1 && !bitmap[w][b])
							b++;
						bitmap[w][b] = 1'b0;
						free_pages--;
						e.page_number_out = pfba_pkg::PAGE_W'(w * WORD_BITS + b);
					end
				end
				pfba_pkg::KIND_FREE: begin
					if (r.page_number >= lim) begin
						e.status = pfba_pkg::ST_RANGE;
					end else if (bitmap[r.page_number / WORD_BITS][r.page_number % WORD_BITS]) begin
						e.status = pfba_pkg::ST_AGAIN;
					end else begin
						bitmap[r.page_number / WORD_BITS][r.page_number % WORD_BITS] = 1'b1;
						free_pages++;
					end
				end
				pfba_pkg::KIND_INIT: begin
					foreach (bitmap[i])
						bitmap[i] = '0;
					free_pages = 0;
					for (int p = first_free; p < lim; p++) begin
						bitmap[p / WORD_BITS][p % WORD_BITS] = 1'b1;
						free_pages++;
					end
				end
				default: ;
			endcase
			e.free_count = pfba_pkg::CFG_W'(free_pages);
			awaited_rsp.push_back(e);
		endfunction

		function void check_response(input pfba_pkg::rsp_t got);
			pfba_pkg::rsp_t want;
			if (awaited_rsp.size() == 0) begin
				$display("%0t: response %h arrived with no request outstanding", $time, got);
				mismatches++;
				return;
			end
			want = awaited_rsp.pop_front();
			if (got.page_number_out !== want.page_number_out) begin
				$display("%0t: page_number_out expected %0d actual %0d", $time,
					want.page_number_out, got.page_number_out);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				mismatches++;
			end
			if (got.free_count !== want.free_count) begin
				$display("%0t: free_count expected %0d actual %0d", $time,
					want.free_count, got.free_count);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	pfba_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	pfba_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pfba_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pfba_pkg::CFG_W-1:0] cfg_data = '0;

	alloc_scoreboard sb;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int idle_cycles = 0;

	page_frame_bitmap_allocator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Response side: check every transfer, then pick the stall for the next cycle.
	always @(posedge clk) begin
		if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
			sb.check_response(rsp);
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Called just after a rising edge; returns at the edge where the request transfer happens.
	task automatic issue_request(input logic [1:0] kind, input logic [pfba_pkg::PAGE_W-1:0] page);
		pfba_pkg::req_t r;
		r.kind = kind;
		r.page_number = page;
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		while (sb.awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_limits(input logic [pfba_pkg::CFG_W-1:0] first,
			input logic [pfba_pkg::CFG_W-1:0] tot);
		cfg_valid <= 1'b1;
		cfg_index <= pfba_pkg::CFG_FIRST_FREE;
		cfg_data <= first;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(pfba_pkg::CFG_FIRST_FREE, first);
		cfg_index <= pfba_pkg::CFG_TOTAL;
		cfg_data <= tot;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(pfba_pkg::CFG_TOTAL, tot);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int pick;
		int lim;
		int p;
		int tries;
		logic [pfba_pkg::CFG_W-1:0] first;
		logic [pfba_pkg::CFG_W-1:0] tot;
		logic [1:0] kind;
		logic [pfba_pkg::PAGE_W-1:0] page;

		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Before any initialize the map is empty, but frees within the total still land.
		issue_request(pfba_pkg::KIND_ALLOC, 10'd0);
		issue_request(pfba_pkg::KIND_FREE, 10'd1023);
		issue_request(pfba_pkg::KIND_FREE, 10'd1023);
		issue_request(KIND_UNUSED, 10'h3ff);
		issue_request(pfba_pkg::KIND_ALLOC, 10'd0);
		issue_request(pfba_pkg::KIND_INIT, 10'h155);
		issue_request(pfba_pkg::KIND_ALLOC, 10'h2aa);
		issue_request(pfba_pkg::KIND_ALLOC, 10'd0);
		issue_request(pfba_pkg::KIND_FREE, 10'd0);
		issue_request(pfba_pkg::KIND_FREE, 10'd992);

		// First page at the total: nothing free; a page below the first can still be freed.
		drain_responses();
		program_limits(11'd1024, 11'd1024);
		issue_request(pfba_pkg::KIND_INIT, 10'd0);
		issue_request(pfba_pkg::KIND_ALLOC, 10'd0);
		issue_request(pfba_pkg::KIND_FREE, 10'd5);
		issue_request(pfba_pkg::KIND_ALLOC, 10'd0);

		// A total above the page count is clamped.
		drain_responses();
		program_limits(11'd0, 11'd2047);
		issue_request(pfba_pkg::KIND_FREE, 10'd1023);
		issue_request(pfba_pkg::KIND_INIT, 10'd0);

		drain_responses();
		program_limits(11'd0, 11'd0);
		issue_request(pfba_pkg::KIND_FREE, 10'd0);
		issue_request(pfba_pkg::KIND_INIT, 10'd0);
		issue_request(pfba_pkg::KIND_ALLOC, 10'd0);

		drain_responses();
		program_limits(11'd1000, 11'd1010);
		issue_request(pfba_pkg::KIND_INIT, 10'd0);
		issue_request(pfba_pkg::KIND_ALLOC, 10'd0);
		issue_request(pfba_pkg::KIND_FREE, 10'd1010);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_responses();
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 53; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 53; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			case (ph)
				0: begin first = 11'd0; tot = 11'd1024; end
				1: begin first = 11'd37; tot = 11'd200; end
				2: begin first = 11'd0; tot = 11'd40; end
				3: begin first = 11'd1000; tot = 11'd2047; end
				4: begin first = 11'd1024; tot = 11'd0; end
				5: begin first = 11'd300; tot = 11'd100; end
				6: begin first = 11'd5; tot = 11'd64; end
				default: begin
					first = pfba_pkg::CFG_W'($urandom_range(0, 1024));
					tot = pfba_pkg::CFG_W'($urandom_range(0, 2047));
				end
			endcase
			program_limits(first, tot);
			issue_request(pfba_pkg::KIND_INIT, pfba_pkg::PAGE_W'($urandom_range(0, 1023)));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Let the block run completely dry once in a while.
				if (n == ITEMS_PER_PHASE / 2 && ph % 2 == 1) begin
					req_valid <= 1'b0;
					while (sb.awaited_rsp.size() != 0)
						@(posedge clk);
				end
				pick = $urandom_range(0, 99);
				page = pfba_pkg::PAGE_W'($urandom_range(0, 1023));
				if (pick < 45) begin
					kind = pfba_pkg::KIND_ALLOC;
				end else if (pick < 88) begin
					kind = pfba_pkg::KIND_FREE;
					lim = sb.page_limit();
					// Mostly return a page that is really in use.
					if (lim > 0 && $urandom_range(0, 99) < 70) begin
						tries = 0;
						p = $urandom_range(0, lim - 1);
						while (sb.bitmap[p / WORD_BITS][p % WORD_BITS] && tries < 8) begin
							p = $urandom_range(0, lim - 1);
							tries++;
						end
						page = pfba_pkg::PAGE_W'(p);
					end
				end else if (pick < 94) begin
					kind = pfba_pkg::KIND_INIT;
				end else begin
					kind = KIND_UNUSED;
				end
				issue_request(kind, page);
			end
		end

		drain_responses();
		if (sb.mismatches == 0 && sb.awaited_rsp.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: files.f
sv/pfba_pkg.sv
sv/pfba_useq.sv
sv/pfba_dpath.sv
sv/page_frame_bitmap_allocator_top.sv
test/tb_page_frame_bitmap_allocator_top.sv
